// ----- hdl/chrm_pkg.sv -----
package chrm_pkg;

  localparam int SLOT_W      = 4;
  localparam int VNODE_W     = 3;
  localparam int TIME_W      = 64;
  localparam int HALF_W      = 64;
  localparam int KEY_W       = 2 * HALF_W;
  localparam int MAX_SERVERS = 1 << SLOT_W;
  localparam int VNODES      = 8;
  localparam int RING_DEPTH  = 128;
  localparam int RESULT_CAP  = 8;
  localparam int RING_AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int NOTE_W      = $clog2(RESULT_CAP + 1);
  localparam int ENTRY_W     = SLOT_W + KEY_W;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 64'd1000000000;

  localparam logic CMD_HEARTBEAT = 1'b0;
  localparam logic CMD_LOOKUP    = 1'b1;

  // register index as decoded from paddr (8 bytes per register)
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_USE_RING = 1'b1;

  typedef enum logic [1:0] {
    KIND_ANSWER = 2'd0,
    KIND_NONE   = 2'd1,
    KIND_NOTICE = 2'd2
  } kind_t;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  server_slot;
    logic [VNODE_W-1:0] vnode_index;
    logic [TIME_W-1:0]  time_now;
    logic [HALF_W-1:0]  digest_hi;
    logic [HALF_W-1:0]  digest_lo;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] target_slot;
    logic [HALF_W-1:0] from_hi;
    logic [HALF_W-1:0] from_lo;
    logic [HALF_W-1:0] to_hi;
    logic [HALF_W-1:0] to_lo;
    logic              last;
  } out_t;

endpackage

// ----- hdl/chrm_ram.sv -----
module chrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/chrm_mod.sv -----
module chrm_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [chrm_pkg::KEY_W-1:0]  dividend,
  input  logic [chrm_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [chrm_pkg::CNT_W-1:0]  rem
);
  import chrm_pkg::*;

  localparam int STEP_W = $clog2(KEY_W);

  logic [KEY_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;

  // restoring remainder, one dividend bit per cycle from the top
  always_comb begin
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, sh_r[KEY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      trial = trial - {1'b0, div_r};
    end
    if (start) begin
      sh_nxt  = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = trial[CNT_W-1:0];
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hdl/chrm_cfg.sv -----
module chrm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chrm_pkg::PADDR_W-1:0] paddr,
  input  logic [chrm_pkg::PDATA_W-1:0] pwdata,
  output logic [chrm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [chrm_pkg::TIME_W-1:0]  timeout,
  output logic                         use_ring
);
  import chrm_pkg::*;

  logic [TIME_W-1:0] timeout_r, timeout_nxt;
  logic              use_ring_r, use_ring_nxt;
  logic              wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    timeout_nxt  = timeout_r;
    use_ring_nxt = use_ring_r;
    if (wr_en) begin
      unique case (paddr[3])
        REG_TIMEOUT:  timeout_nxt  = pwdata[TIME_W-1:0];
        REG_USE_RING: use_ring_nxt = pwdata[0];
        default:      timeout_nxt  = timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      use_ring_r <= 1'b1;
    end else begin
      timeout_r  <= timeout_nxt;
      use_ring_r <= use_ring_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_TIMEOUT:  prdata = timeout_r;
      REG_USE_RING: prdata = {{(PDATA_W-1){1'b0}}, use_ring_r};
      default:      prdata = '0;
    endcase
  end

  assign pready   = 1'b1;
  assign timeout  = timeout_r;
  assign use_ring = use_ring_r;

endmodule

// ----- hdl/consistent_hash_ring_membership.sv -----
// Ring of up to 128 virtual-node digests (128 bits, tagged with a 4-bit server slot) kept in
// one single-port-read RAM, with per-entry valid flops and per-slot membership and heartbeat
// time. A sweep reads the whole RAM, one entry per cycle: a ring lookup is one sweep; a
// modulo lookup is a bit-serial remainder of the digest by the member count plus a slot
// walk; a heartbeat takes a join sweep when the slot is not yet a member, an expiry walk
// over all 16 slots, and one more sweep if anything expired. The final vnode of a join
// adds one sweep to find the slot's lowest vnode and then one sweep per owned vnode to
// produce transfer notices (at most 8), the last flagged by last. One transaction is in
// flight at a time; a result may sit in the output register while the next one is taken.
// A ring lookup with no valid entries, or a modulo lookup with no members, gives kind one.
module consistent_hash_ring_membership (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  chrm_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output chrm_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chrm_pkg::PADDR_W-1:0] paddr,
  input  logic [chrm_pkg::PDATA_W-1:0] pwdata,
  output logic [chrm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import chrm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_INSERT = 7'b0000100,
    S_EXPIRE = 7'b0001000,
    S_MOD    = 7'b0010000,
    S_PICK   = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    M_JOIN  = 3'd0,
    M_DROP  = 3'd1,
    M_LOOK  = 3'd2,
    M_FIRST = 3'd3,
    M_SUCC  = 3'd4
  } mode_t;

  function automatic out_t make_note(logic [SLOT_W-1:0] own, logic [KEY_W-1:0] from_key,
                                     logic [KEY_W-1:0] to_key);
    out_t n;
    n.kind        = KIND_NOTICE;
    n.target_slot = own;
    n.from_hi     = from_key[KEY_W-1:HALF_W];
    n.from_lo     = from_key[HALF_W-1:0];
    n.to_hi       = to_key[KEY_W-1:HALF_W];
    n.to_lo       = to_key[HALF_W-1:0];
    n.last        = 1'b0;
    return n;
  endfunction

  function automatic out_t make_answer(kind_t k, logic [SLOT_W-1:0] own);
    out_t n;
    n         = '0;
    n.kind    = k;
    n.target_slot = own;
    n.last    = 1'b1;
    return n;
  endfunction

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  in_t                 item_r, item_nxt;
  logic [KEY_W-1:0]    ref_key_r, ref_key_nxt;
  logic [RING_AW:0]    scan_cnt_r, scan_cnt_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [RING_AW-1:0]  p_idx_r, p_idx_nxt;
  logic                a_found_r, a_found_nxt, b_found_r, b_found_nxt;
  logic [KEY_W-1:0]    a_key_r, a_key_nxt, b_key_r, b_key_nxt;
  logic [SLOT_W-1:0]   a_own_r, a_own_nxt, b_own_r, b_own_nxt;
  logic [RING_AW-1:0]  a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;
  logic [RING_DEPTH-1:0]  valid_r, valid_nxt;
  logic [MAX_SERVERS-1:0] member_r, member_nxt;
  logic [TIME_W-1:0]   ls_r [MAX_SERVERS];
  logic [TIME_W-1:0]   ls_nxt [MAX_SERVERS];
  logic [SLOT_W-1:0]   exp_cnt_r, exp_cnt_nxt;
  logic [MAX_SERVERS-1:0] exp_mask_r, exp_mask_nxt;
  logic                join_last_r, join_last_nxt;
  logic [NOTE_W-1:0]   n_r, n_nxt;
  out_t                pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                push_last_r, push_last_nxt;
  logic                aft_store_r, aft_store_nxt;
  out_t                out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0]   pick_cnt_r, pick_cnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  logic                ram_re, ram_we;
  logic [RING_AW-1:0]  ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    e_key;
  logic [SLOT_W-1:0]   e_own;
  logic                e_valid, own_match;
  logic                e_lt_a, e_lt_b, e_lt_ref, ref_lt_e;
  logic [TIME_W-1:0]   timeout;
  logic                use_ring;
  logic [CNT_W-1:0]    mem_count;
  logic                mod_start, mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic [TIME_W:0]     age;
  logic                expired;

  chrm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timeout  (timeout),
    .use_ring (use_ring)
  );

  chrm_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_cnt_r[RING_AW-1:0]),
    .rdata (ram_rdata)
  );

  chrm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend ({in_data.digest_hi, in_data.digest_lo}),
    .divisor  (mem_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign ram_re    = (state_r == S_SCAN) && (scan_cnt_r < (RING_AW+1)'(RING_DEPTH));
  assign e_own     = ram_rdata[ENTRY_W-1 -: SLOT_W];
  assign e_key     = ram_rdata[KEY_W-1:0];
  assign e_valid   = valid_r[p_idx_r];
  assign own_match = (e_own == item_r.server_slot);
  assign e_lt_a    = e_key < a_key_r;
  assign e_lt_b    = e_key < b_key_r;
  assign e_lt_ref  = e_key < ref_key_r;
  assign ref_lt_e  = ref_key_r < e_key;

  assign age     = {1'b0, item_r.time_now} - {1'b0, ls_r[exp_cnt_r]};
  assign expired = member_r[exp_cnt_r] && !age[TIME_W] && (age[TIME_W-1:0] > timeout);

  always_comb begin
    mem_count = '0;
    for (int s = 0; s < MAX_SERVERS; s++) begin
      mem_count = mem_count + CNT_W'(member_r[s]);
    end
  end

  always_comb begin
    logic              upd_a, upd_b, new_note, have_pend;
    logic [NOTE_W-1:0] n_val;
    out_t              note;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    item_nxt      = item_r;
    ref_key_nxt   = ref_key_r;
    scan_cnt_nxt  = scan_cnt_r;
    p_vld_nxt     = 1'b0;
    p_idx_nxt     = p_idx_r;
    a_found_nxt   = a_found_r;
    a_key_nxt     = a_key_r;
    a_own_nxt     = a_own_r;
    a_idx_nxt     = a_idx_r;
    b_found_nxt   = b_found_r;
    b_key_nxt     = b_key_r;
    b_own_nxt     = b_own_r;
    b_idx_nxt     = b_idx_r;
    valid_nxt     = valid_r;
    member_nxt    = member_r;
    ls_nxt        = ls_r;
    exp_cnt_nxt   = exp_cnt_r;
    exp_mask_nxt  = exp_mask_r;
    join_last_nxt = join_last_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    push_last_nxt = push_last_r;
    aft_store_nxt = aft_store_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    pick_cnt_nxt  = pick_cnt_r;
    rem_nxt       = rem_r;
    ram_we        = 1'b0;
    ram_waddr     = a_idx_r;
    ram_wdata     = {item_r.server_slot, ref_key_r};
    mod_start     = 1'b0;
    upd_a         = 1'b0;
    upd_b         = 1'b0;
    new_note      = 1'b0;
    have_pend     = pend_vld_r;
    n_val         = n_r;
    note          = make_note(a_own_r, ref_key_r, a_key_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          ref_key_nxt = {in_data.digest_hi, in_data.digest_lo};
          if (in_data.cmd == CMD_LOOKUP) begin
            if (use_ring) begin
              mode_nxt     = M_LOOK;
              scan_cnt_nxt = '0;
              a_found_nxt  = 1'b0;
              b_found_nxt  = 1'b0;
              state_nxt    = S_SCAN;
            end else if (mem_count == '0) begin
              pend_nxt      = make_answer(KIND_NONE, '0);
              push_last_nxt = 1'b1;
              aft_store_nxt = 1'b0;
              state_nxt     = S_PUSH;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
          end else if (member_r[in_data.server_slot]) begin
            ls_nxt[in_data.server_slot] = in_data.time_now;
            join_last_nxt = 1'b0;
            exp_cnt_nxt   = '0;
            exp_mask_nxt  = '0;
            state_nxt     = S_EXPIRE;
          end else begin
            mode_nxt     = M_JOIN;
            scan_cnt_nxt = '0;
            a_found_nxt  = 1'b0;
            b_found_nxt  = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ram_re) begin
          scan_cnt_nxt = scan_cnt_r + (RING_AW+1)'(1);
        end
        p_vld_nxt = ram_re;
        p_idx_nxt = scan_cnt_r[RING_AW-1:0];
        if (p_vld_r) begin
          unique case (mode_r)
            M_JOIN: begin
              // a restarted join drops the slot's old entries in the same sweep
              if (e_valid && item_r.vnode_index == '0 && own_match) begin
                valid_nxt[p_idx_r] = 1'b0;
                upd_b = !b_found_r;
              end else if (e_valid) begin
                upd_a = !a_found_r && (e_key == ref_key_r);
              end else begin
                upd_b = !b_found_r;
              end
            end
            M_DROP: begin
              if (e_valid && exp_mask_r[e_own]) begin
                valid_nxt[p_idx_r] = 1'b0;
              end
            end
            M_LOOK: begin
              upd_a = e_valid && !e_lt_ref && (!a_found_r || e_lt_a);
              upd_b = e_valid && (!b_found_r || e_lt_b);
            end
            M_FIRST: begin
              upd_a = e_valid && own_match && (!a_found_r || e_lt_a);
            end
            M_SUCC: begin
              upd_a = e_valid && ref_lt_e && (!a_found_r || e_lt_a);
              upd_b = e_valid && ref_lt_e && own_match && (!b_found_r || e_lt_b);
            end
            default: begin
              upd_a = 1'b0;
            end
          endcase
          if (upd_a) begin
            a_found_nxt = 1'b1;
            a_key_nxt   = e_key;
            a_own_nxt   = e_own;
            a_idx_nxt   = p_idx_r;
          end
          if (upd_b) begin
            b_found_nxt = 1'b1;
            b_key_nxt   = e_key;
            b_own_nxt   = e_own;
            b_idx_nxt   = p_idx_r;
          end

          if (p_idx_r == RING_AW'(RING_DEPTH - 1)) begin
            unique case (mode_r)
              M_JOIN: state_nxt = S_INSERT;
              M_DROP: begin
                if (join_last_r) begin
                  n_nxt        = '0;
                  mode_nxt     = M_FIRST;
                  scan_cnt_nxt = '0;
                  a_found_nxt  = 1'b0;
                  b_found_nxt  = 1'b0;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
              M_LOOK: begin
                if (a_found_nxt) begin
                  pend_nxt = make_answer(KIND_ANSWER, a_own_nxt);
                end else if (b_found_nxt) begin
                  pend_nxt = make_answer(KIND_ANSWER, b_own_nxt);
                end else begin
                  pend_nxt = make_answer(KIND_NONE, '0);
                end
                push_last_nxt = 1'b1;
                aft_store_nxt = 1'b0;
                state_nxt     = S_PUSH;
              end
              M_FIRST: begin
                if (a_found_nxt) begin
                  ref_key_nxt  = a_key_nxt;
                  mode_nxt     = M_SUCC;
                  scan_cnt_nxt = '0;
                  a_found_nxt  = 1'b0;
                  b_found_nxt  = 1'b0;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
              M_SUCC: begin
                new_note = a_found_nxt && (a_own_nxt != item_r.server_slot);
                note     = make_note(a_own_nxt, ref_key_r, a_key_nxt);
                if (new_note && pend_vld_r) begin
                  // older notice goes out first, then this one is held back
                  push_last_nxt = 1'b0;
                  aft_store_nxt = 1'b1;
                  state_nxt     = S_PUSH;
                end else begin
                  if (new_note) begin
                    pend_nxt     = note;
                    pend_vld_nxt = 1'b1;
                    n_val        = n_r + NOTE_W'(1);
                    have_pend    = 1'b1;
                  end
                  n_nxt = n_val;
                  if (n_val == NOTE_W'(RESULT_CAP) || !b_found_nxt) begin
                    if (have_pend) begin
                      push_last_nxt = 1'b1;
                      aft_store_nxt = 1'b0;
                      state_nxt     = S_PUSH;
                    end else begin
                      state_nxt = S_IDLE;
                    end
                  end else begin
                    ref_key_nxt  = b_key_nxt;
                    scan_cnt_nxt = '0;
                    a_found_nxt  = 1'b0;
                    b_found_nxt  = 1'b0;
                  end
                end
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_INSERT: begin
        if (a_found_r) begin
          ram_we    = 1'b1;
          ram_waddr = a_idx_r;
        end else if (b_found_r) begin
          ram_we               = 1'b1;
          ram_waddr            = b_idx_r;
          valid_nxt[b_idx_r]   = 1'b1;
        end
        if (item_r.vnode_index == VNODE_W'(VNODES - 1)) begin
          member_nxt[item_r.server_slot] = 1'b1;
          ls_nxt[item_r.server_slot]     = item_r.time_now;
          join_last_nxt = 1'b1;
        end else begin
          join_last_nxt = 1'b0;
        end
        exp_cnt_nxt  = '0;
        exp_mask_nxt = '0;
        state_nxt    = S_EXPIRE;
      end

      S_EXPIRE: begin
        if (expired) begin
          member_nxt[exp_cnt_r]   = 1'b0;
          exp_mask_nxt[exp_cnt_r] = 1'b1;
        end
        exp_cnt_nxt = exp_cnt_r + SLOT_W'(1);
        if (exp_cnt_r == SLOT_W'(MAX_SERVERS - 1)) begin
          if (exp_mask_nxt != '0) begin
            mode_nxt     = M_DROP;
            scan_cnt_nxt = '0;
            state_nxt    = S_SCAN;
          end else if (join_last_r) begin
            n_nxt        = '0;
            mode_nxt     = M_FIRST;
            scan_cnt_nxt = '0;
            a_found_nxt  = 1'b0;
            b_found_nxt  = 1'b0;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          rem_nxt      = mod_rem;
          pick_cnt_nxt = '0;
          state_nxt    = S_PICK;
        end
      end

      S_PICK: begin
        pick_cnt_nxt = pick_cnt_r + SLOT_W'(1);
        if (member_r[pick_cnt_r]) begin
          if (rem_r == '0) begin
            pend_nxt      = make_answer(KIND_ANSWER, pick_cnt_r);
            push_last_nxt = 1'b1;
            aft_store_nxt = 1'b0;
            state_nxt     = S_PUSH;
          end else begin
            rem_nxt = rem_r - CNT_W'(1);
          end
        end
      end

      S_PUSH: begin
        if (!out_vld_r || out_ready) begin
          out_nxt      = pend_r;
          out_nxt.last = push_last_r;
          out_vld_nxt  = 1'b1;
          pend_vld_nxt = 1'b0;
          if (aft_store_r) begin
            pend_nxt     = note;
            pend_vld_nxt = 1'b1;
            n_val        = n_r + NOTE_W'(1);
            n_nxt        = n_val;
            if (n_val == NOTE_W'(RESULT_CAP) || !b_found_r) begin
              push_last_nxt = 1'b1;
              aft_store_nxt = 1'b0;
            end else begin
              ref_key_nxt  = b_key_r;
              mode_nxt     = M_SUCC;
              scan_cnt_nxt = '0;
              a_found_nxt  = 1'b0;
              b_found_nxt  = 1'b0;
              state_nxt    = S_SCAN;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      p_vld_r    <= 1'b0;
      valid_r    <= '0;
      member_r   <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p_vld_r    <= p_vld_nxt;
      valid_r    <= valid_nxt;
      member_r   <= member_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    item_r      <= item_nxt;
    ref_key_r   <= ref_key_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    p_idx_r     <= p_idx_nxt;
    a_found_r   <= a_found_nxt;
    a_key_r     <= a_key_nxt;
    a_own_r     <= a_own_nxt;
    a_idx_r     <= a_idx_nxt;
    b_found_r   <= b_found_nxt;
    b_key_r     <= b_key_nxt;
    b_own_r     <= b_own_nxt;
    b_idx_r     <= b_idx_nxt;
    ls_r        <= ls_nxt;
    exp_cnt_r   <= exp_cnt_nxt;
    exp_mask_r  <= exp_mask_nxt;
    join_last_r <= join_last_nxt;
    n_r         <= n_nxt;
    pend_r      <= pend_nxt;
    push_last_r <= push_last_nxt;
    aft_store_r <= aft_store_nxt;
    out_r       <= out_nxt;
    pick_cnt_r  <= pick_cnt_nxt;
    rem_r       <= rem_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
